### rtl/mfld_pkg.sv
// shared types and constants for the monochrome framebuffer line drawer
// no dependencies
package mfld_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;
   localparam int PAGE_ROWS         = 8;
   localparam int IDX_W             = 14;
   localparam int ERR_W             = 11;

   localparam logic [7:0] FILL_ON  = 8'hFF;
   localparam logic [7:0] FILL_OFF = 8'h00;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_FILL  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      ST_FILL      = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_PLOT_RD   = 6'b000100,
      ST_PLOT_WR   = 6'b001000,
      ST_READ_WAIT = 6'b010000,
      ST_DONE      = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } walk_ctl_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       at_end;
   } walk_stat_type;

endpackage

### rtl/mfld_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mfld_line_walk.sv
// bresenham error-term stepper, one pixel per step
// depends on mfld_pkg
module mfld_line_walk (
   input  logic                   clock,
   input  mfld_pkg::walk_ctl_type ctl,
   input  logic [7:0]             load_x0,
   input  logic [7:0]             load_y0,
   input  logic [7:0]             load_x1,
   input  logic [7:0]             load_y1,
   output mfld_pkg::walk_stat_type stat
);

   localparam int EW = mfld_pkg::ERR_W;

   logic [7:0]           x_ff, x_in;
   logic [7:0]           y_ff, y_in;
   logic [7:0]           xe_ff, xe_in;
   logic [7:0]           ye_ff, ye_in;
   logic signed [EW-1:0] dx_ff, dx_in;
   logic signed [EW-1:0] dy_ff, dy_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic                 sx_neg_ff, sx_neg_in;
   logic                 sy_neg_ff, sy_neg_in;

   logic [7:0]           adx;
   logic [7:0]           ady;
   logic signed [EW:0]   e2;
   logic signed [EW:0]   dx_ext;
   logic signed [EW:0]   dy_ext;
   logic                 go_x;
   logic                 go_y;

   assign adx    = (load_x1 > load_x0) ? load_x1 - load_x0 : load_x0 - load_x1;
   assign ady    = (load_y1 > load_y0) ? load_y1 - load_y0 : load_y0 - load_y1;
   assign e2     = {err_ff, 1'b0};
   assign dx_ext = (EW+1)'(dx_ff);
   assign dy_ext = (EW+1)'(dy_ff);
   assign go_x   = (e2 >= dy_ext);
   assign go_y   = (e2 <= dx_ext);

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      xe_in     = xe_ff;
      ye_in     = ye_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      if (ctl.load) begin
         x_in      = load_x0;
         y_in      = load_y0;
         xe_in     = load_x1;
         ye_in     = load_y1;
         dx_in     = $signed({{(EW-8){1'b0}}, adx});
         dy_in     = -$signed({{(EW-8){1'b0}}, ady});
         err_in    = $signed({{(EW-8){1'b0}}, adx}) - $signed({{(EW-8){1'b0}}, ady});
         sx_neg_in = !(load_x0 < load_x1);
         sy_neg_in = !(load_y0 < load_y1);
      end else if (ctl.step) begin
         err_in = err_ff + (go_x ? dy_ff : '0) + (go_y ? dx_ff : '0);
         if (go_x) begin
            x_in = sx_neg_ff ? x_ff - 8'd1 : x_ff + 8'd1;
         end
         if (go_y) begin
            y_in = sy_neg_ff ? y_ff - 8'd1 : y_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      xe_ff     <= xe_in;
      ye_ff     <= ye_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      err_ff    <= err_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
   end

   assign stat.x      = x_ff;
   assign stat.y      = y_ff;
   assign stat.at_end = (x_ff == xe_ff) && (y_ff == ye_ff);

endmodule

### rtl/mono_framebuffer_line_draw.sv
// monochrome page framebuffer with pixel, line, fill and read commands
// depends on mfld_pkg, mfld_ram, mfld_line_walk
//
// usage: one command word enters on req_ when req_valid and req_ready are
// high; exactly one word leaves on rsp_ per command, rsp_read_data holding
// the stored byte for an in-range read and zero otherwise. rsp_ is a registered
// output stage: it holds its word while rsp_ready is low, and the block
// takes the next command meanwhile, stalling only when a second result is
// ready before the first one left.
// steps per command, set by the one ram port pair and the line stepper:
//   pixel: read then write of its byte if on screen, then done
//   line:  read and write per on-screen pixel, a bare step per off-screen pixel
//   fill:  one write per store byte (1024 at the default size), then done
//   read:  ram read, wait for the data, then done
// each on-screen pixel is a read-modify-write of one byte through the ram.
// after reset the store is swept to zero, one byte per cycle; req_ready
// stays low for that pass over all 1024 bytes at the default size.
module mono_framebuffer_line_draw #(
   parameter int SCREEN_WIDTH  = mfld_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = mfld_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_start_x,
   input  logic [7:0] req_start_y,
   input  logic [7:0] req_end_x,
   input  logic [7:0] req_end_y,
   input  logic       req_ink,
   input  logic [9:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);

   localparam int PAGES       = (SCREEN_HEIGHT + mfld_pkg::PAGE_ROWS - 1) / mfld_pkg::PAGE_ROWS;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int IW          = mfld_pkg::IDX_W;

   mfld_pkg::state_type     state_ff, state_in;
   logic [ADDR_W-1:0]       fill_cnt_ff, fill_cnt_in;
   logic [7:0]              fill_data_ff, fill_data_in;
   logic                    clearing_ff, clearing_in;
   logic                    ink_ff, ink_in;
   logic                    read_ok_ff, read_ok_in;
   logic [7:0]              pend_data_ff, pend_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   mfld_pkg::walk_ctl_type  walk_ctl;
   mfld_pkg::walk_stat_type walk_stat;
   logic [7:0]              load_x1;
   logic [7:0]              load_y1;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [7:0]              wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [7:0]              rd_data;

   logic [IW-1:0]           pix_index;
   logic [ADDR_W-1:0]       pix_addr;
   logic [7:0]              pix_mask;
   logic                    on_screen;
   logic                    read_in_range;
   logic                    req_fire;
   logic                    rsp_free;
   mfld_pkg::kind_type      kind;

   assign kind          = mfld_pkg::kind_type'(req_kind);
   assign req_ready     = (state_ff == mfld_pkg::ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign load_x1       = (kind == mfld_pkg::KIND_LINE) ? req_end_x : req_start_x;
   assign load_y1       = (kind == mfld_pkg::KIND_LINE) ? req_end_y : req_start_y;
   assign pix_index     = IW'(walk_stat.x) + IW'(walk_stat.y[7:3]) * IW'(SCREEN_WIDTH);
   assign pix_addr      = pix_index[ADDR_W-1:0];
   assign pix_mask      = 8'd1 << walk_stat.y[2:0];
   assign on_screen     = ({1'b0, walk_stat.x} < 9'(SCREEN_WIDTH))
                          && ({1'b0, walk_stat.y} < 9'(SCREEN_HEIGHT));
   assign read_in_range = IW'(req_read_index) < IW'(STORE_BYTES);

   always_comb begin
      state_in     = state_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_data_in = fill_data_ff;
      clearing_in  = clearing_ff;
      ink_in       = ink_ff;
      read_ok_in   = read_ok_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      walk_ctl     = '0;
      wr_en        = 1'b0;
      wr_addr      = pix_addr;
      wr_data      = ink_ff ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
      rd_en        = 1'b0;
      rd_addr      = pix_addr;
      unique case (state_ff)
         mfld_pkg::ST_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = fill_cnt_ff;
            wr_data     = fill_data_ff;
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = clearing_ff ? mfld_pkg::ST_IDLE : mfld_pkg::ST_DONE;
            end
         end
         mfld_pkg::ST_IDLE: begin
            if (req_fire) begin
               ink_in       = req_ink;
               pend_data_in = '0;
               unique case (kind)
                  mfld_pkg::KIND_PIXEL, mfld_pkg::KIND_LINE: begin
                     walk_ctl.load = 1'b1;
                     state_in      = mfld_pkg::ST_PLOT_RD;
                  end
                  mfld_pkg::KIND_FILL: begin
                     fill_cnt_in  = '0;
                     fill_data_in = req_ink ? mfld_pkg::FILL_ON : mfld_pkg::FILL_OFF;
                     clearing_in  = 1'b0;
                     state_in     = mfld_pkg::ST_FILL;
                  end
                  mfld_pkg::KIND_READ: begin
                     rd_en      = read_in_range;
                     rd_addr    = ADDR_W'(req_read_index) & {ADDR_W{read_in_range}};
                     read_ok_in = read_in_range;
                     state_in   = mfld_pkg::ST_READ_WAIT;
                  end
               endcase
            end
         end
         mfld_pkg::ST_PLOT_RD: begin
            priority if (on_screen) begin
               rd_en    = 1'b1;
               state_in = mfld_pkg::ST_PLOT_WR;
            end else if (walk_stat.at_end) begin
               state_in = mfld_pkg::ST_DONE;
            end else begin
               walk_ctl.step = 1'b1;
            end
         end
         mfld_pkg::ST_PLOT_WR: begin
            wr_en = 1'b1;
            if (walk_stat.at_end) begin
               state_in = mfld_pkg::ST_DONE;
            end else begin
               walk_ctl.step = 1'b1;
               state_in      = mfld_pkg::ST_PLOT_RD;
            end
         end
         mfld_pkg::ST_READ_WAIT: begin
            pend_data_in = read_ok_ff ? rd_data : '0;
            state_in     = mfld_pkg::ST_DONE;
         end
         mfld_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_data_ff;
               state_in     = mfld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfld_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfld_pkg::ST_FILL;
         fill_cnt_ff  <= '0;
         fill_data_ff <= mfld_pkg::FILL_OFF;
         clearing_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         fill_data_ff <= fill_data_in;
         clearing_ff  <= clearing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ink_ff       <= ink_in;
      read_ok_ff   <= read_ok_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   mfld_line_walk u_walk (
      .clock   (clock),
      .ctl     (walk_ctl),
      .load_x0 (req_start_x),
      .load_y0 (req_start_y),
      .load_x1 (load_x1),
      .load_y1 (load_y1),
      .stat    (walk_stat)
   );

   mfld_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

### rtl/mfld_checker.sv
// port-level checks for the framebuffer line drawer, bound to the top level
// depends on mono_framebuffer_line_draw
module mfld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data
);

   // result word holds while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("rsp word changed while stalled");

   // clearing pass keeps the input closed right after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during clearing pass");

   // every accepted command lowers req_ready in the cycle after it is taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a command");

endmodule

bind mono_framebuffer_line_draw mfld_checker u_mfld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data)
);
